@@ design/wfgd_pkg.sv @@
// ----------------------------------------------------------------------------
// wfgd_pkg
// Shared types and constants of the wait-for graph deadlock detector.
// ----------------------------------------------------------------------------
package wfgd_pkg;

  // Default table sizes
  localparam int DEF_PROCESS_SLOTS  = 8;
  localparam int DEF_RESOURCE_COUNT = 16;

  // Fixed widths of the word fields
  localparam int OP_W   = 2;
  localparam int SLOT_W = 3;
  localparam int RES_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_HOLD  = 2'd0,
    OP_WAIT  = 2'd1,
    OP_CHECK = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

endpackage

@@ design/wait_for_graph_deadlock_detector.sv @@
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector
// Lock table with holder and wait memories and a depth-first cycle search.
// ----------------------------------------------------------------------------
// One word is handled at a time. A hold and a clear are done in the idle state;
// a wait reads the slot's wait row, then modifies it and writes it back in
// ST_WAITWR. A check walks the start slots one at a time and, for every node it
// visits, scans the node's wait row one resource position per cycle; each edge
// followed passes through ST_HOLDER for the holder memory read, and each return
// to a parent through ST_POP for the stack read. A check result sits in an
// output register, so further words are accepted while it waits to be taken.
module wait_for_graph_deadlock_detector #(
  parameter int PROCESS_SLOTS  = wfgd_pkg::DEF_PROCESS_SLOTS,
  parameter int RESOURCE_COUNT = wfgd_pkg::DEF_RESOURCE_COUNT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [wfgd_pkg::OP_W-1:0]   op_i,
  input  logic [wfgd_pkg::SLOT_W-1:0] process_slot_i,
  input  logic [wfgd_pkg::RES_W-1:0]  resource_id_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        deadlock_found_o,
  output logic [wfgd_pkg::SLOT_W-1:0] closing_slot_o
);

  localparam int SW  = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int RW  = (RESOURCE_COUNT > 1) ? $clog2(RESOURCE_COUNT) : 1;
  localparam int SPW = $clog2(PROCESS_SLOTS + 1);
  localparam int CW  = $clog2(RESOURCE_COUNT + 1);
  localparam int FW  = SW + CW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WAITWR = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_HOLDER = 3'd4;
  localparam logic [2:0] ST_POP    = 3'd5;
  localparam logic [2:0] ST_REPORT = 3'd6;

  // Memories
  logic [RESOURCE_COUNT-1:0] wait_mem   [PROCESS_SLOTS];
  logic [SW-1:0]             holder_mem [RESOURCE_COUNT];
  logic [FW-1:0]             stack_mem  [PROCESS_SLOTS];

  // Memory ports
  logic                      wait_re, wait_we;
  logic [SW-1:0]             wait_raddr, wait_waddr;
  logic [RESOURCE_COUNT-1:0] wait_wdata, wait_rdata_q;
  logic                      wait_rvld_q;
  logic                      holder_re, holder_we;
  logic [RW-1:0]             holder_raddr, holder_waddr;
  logic [SW-1:0]             holder_wdata, holder_rdata_q;
  logic                      stack_re, stack_we;
  logic [SW-1:0]             stack_raddr, stack_waddr;
  logic [FW-1:0]             stack_wdata, stack_rdata_q;

  // Control state
  logic [2:0]                state_q, state_d;
  logic [PROCESS_SLOTS-1:0]  active_q, active_d;
  logic [PROCESS_SLOTS-1:0]  on_path_q, on_path_d;
  logic [PROCESS_SLOTS-1:0]  done_q, done_d;
  logic [PROCESS_SLOTS-1:0]  row_vld_q, row_vld_d;
  logic [RESOURCE_COUNT-1:0] holder_vld_q, holder_vld_d;
  logic [SW-1:0]             cur_slot_q, cur_slot_d;
  logic [CW-1:0]             cursor_q, cursor_d;
  logic [SPW-1:0]            sp_q, sp_d;
  logic [SPW-1:0]            start_q, start_d;
  logic [SW-1:0]             wr_slot_q, wr_slot_d;
  logic [RW-1:0]             wr_res_q, wr_res_d;
  logic                      found_q, found_d;
  logic [SW-1:0]             closing_q, closing_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_found_q, out_found_d;
  logic [wfgd_pkg::SLOT_W-1:0] out_closing_q, out_closing_d;

  wfgd_pkg::op_e             op;
  logic                      accept;
  logic                      in_range;
  logic [SW-1:0]             in_slot;
  logic [RW-1:0]             in_res;
  logic [RESOURCE_COUNT-1:0] wait_row;
  logic [RESOURCE_COUNT-1:0] cur_row;
  logic [RW-1:0]             cur_idx;
  logic                      cursor_end;
  logic [SPW-1:0]            sp_m1, sp_m2;
  logic [SW-1:0]             start_slot;

  assign op         = wfgd_pkg::op_e'(op_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(process_slot_i) < 32'(PROCESS_SLOTS)) &&
                      (32'(resource_id_i) < 32'(RESOURCE_COUNT));
  assign in_slot    = SW'(process_slot_i);
  assign in_res     = RW'(resource_id_i);

  // Row from the wait memory; a row never written reads as zero
  assign wait_row   = wait_rvld_q ? wait_rdata_q : '0;
  // Waits on unheld resources add no edge
  assign cur_row    = wait_row & holder_vld_q;
  assign cur_idx    = cursor_q[RW-1:0];
  assign cursor_end = (cursor_q == CW'(RESOURCE_COUNT));
  assign sp_m1      = sp_q - SPW'(1);
  assign sp_m2      = sp_q - SPW'(2);
  assign start_slot = start_q[SW-1:0];

  always_comb begin
    state_d       = state_q;
    active_d      = active_q;
    on_path_d     = on_path_q;
    done_d        = done_q;
    row_vld_d     = row_vld_q;
    holder_vld_d  = holder_vld_q;
    cur_slot_d    = cur_slot_q;
    cursor_d      = cursor_q;
    sp_d          = sp_q;
    start_d       = start_q;
    wr_slot_d     = wr_slot_q;
    wr_res_d      = wr_res_q;
    found_d       = found_q;
    closing_d     = closing_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_found_d   = out_found_q;
    out_closing_d = out_closing_q;

    wait_re       = 1'b0;
    wait_raddr    = cur_slot_q;
    wait_we       = 1'b0;
    wait_waddr    = wr_slot_q;
    wait_wdata    = wait_row | (RESOURCE_COUNT'(1) << wr_res_q);
    holder_re     = 1'b0;
    holder_raddr  = cur_idx;
    holder_we     = 1'b0;
    holder_waddr  = in_res;
    holder_wdata  = in_slot;
    stack_re      = 1'b0;
    stack_raddr   = sp_m2[SW-1:0];
    stack_we      = 1'b0;
    stack_waddr   = sp_m1[SW-1:0];
    stack_wdata   = {cur_slot_q, cursor_q};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            wfgd_pkg::OP_HOLD: begin
              if (in_range) begin
                holder_we             = 1'b1;
                holder_vld_d[in_res]  = 1'b1;
                active_d[in_slot]     = 1'b1;
              end
            end
            wfgd_pkg::OP_WAIT: begin
              if (in_range) begin
                wait_re    = 1'b1;
                wait_raddr = in_slot;
                wr_slot_d  = in_slot;
                wr_res_d   = in_res;
                state_d    = ST_WAITWR;
              end
            end
            wfgd_pkg::OP_CHECK: begin
              on_path_d = '0;
              done_d    = '0;
              start_d   = '0;
              state_d   = ST_START;
            end
            wfgd_pkg::OP_CLEAR: begin
              row_vld_d    = '0;
              holder_vld_d = '0;
              active_d     = '0;
            end
            default: ;
          endcase
        end
      end
      ST_WAITWR: begin
        wait_we              = 1'b1;
        row_vld_d[wr_slot_q] = 1'b1;
        active_d[wr_slot_q]  = 1'b1;
        state_d              = ST_IDLE;
      end
      ST_START: begin
        if (start_q == SPW'(PROCESS_SLOTS)) begin
          found_d   = 1'b0;
          closing_d = '0;
          state_d   = ST_REPORT;
        end else if (active_q[start_slot] && !done_q[start_slot]) begin
          on_path_d[start_slot] = 1'b1;
          cur_slot_d = start_slot;
          cursor_d   = '0;
          sp_d       = SPW'(1);
          wait_re    = 1'b1;
          wait_raddr = start_slot;
          state_d    = ST_SCAN;
        end else begin
          start_d = start_q + SPW'(1);
        end
      end
      ST_SCAN: begin
        if (cursor_end) begin
          // node finished: retire it and return to its parent
          on_path_d[cur_slot_q] = 1'b0;
          done_d[cur_slot_q]    = 1'b1;
          if (sp_q == SPW'(1)) begin
            state_d = ST_START;
          end else begin
            stack_re = 1'b1;
            sp_d     = sp_m1;
            state_d  = ST_POP;
          end
        end else if (cur_row[cur_idx]) begin
          holder_re = 1'b1;
          cursor_d  = cursor_q + CW'(1);
          state_d   = ST_HOLDER;
        end else begin
          cursor_d = cursor_q + CW'(1);
        end
      end
      ST_HOLDER: begin
        if (on_path_q[holder_rdata_q]) begin
          // back edge: circular wait
          found_d   = 1'b1;
          closing_d = holder_rdata_q;
          state_d   = ST_REPORT;
        end else if (done_q[holder_rdata_q]) begin
          state_d = ST_SCAN;
        end else begin
          // a slot off the path and not done leaves room on the stack
          stack_we                  = 1'b1;
          on_path_d[holder_rdata_q] = 1'b1;
          cur_slot_d = holder_rdata_q;
          cursor_d   = '0;
          sp_d       = sp_q + SPW'(1);
          wait_re    = 1'b1;
          wait_raddr = holder_rdata_q;
          state_d    = ST_SCAN;
        end
      end
      ST_POP: begin
        cur_slot_d = stack_rdata_q[FW-1:CW];
        cursor_d   = stack_rdata_q[CW-1:0];
        wait_re    = 1'b1;
        wait_raddr = stack_rdata_q[FW-1:CW];
        state_d    = ST_SCAN;
      end
      ST_REPORT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_found_d   = found_q;
          out_closing_d = wfgd_pkg::SLOT_W'(closing_q);
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      active_q     <= '0;
      on_path_q    <= '0;
      done_q       <= '0;
      row_vld_q    <= '0;
      holder_vld_q <= '0;
      cur_slot_q   <= '0;
      cursor_q     <= '0;
      sp_q         <= '0;
      start_q      <= '0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      on_path_q    <= on_path_d;
      done_q       <= done_d;
      row_vld_q    <= row_vld_d;
      holder_vld_q <= holder_vld_d;
      cur_slot_q   <= cur_slot_d;
      cursor_q     <= cursor_d;
      sp_q         <= sp_d;
      start_q      <= start_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wr_slot_q     <= wr_slot_d;
    wr_res_q      <= wr_res_d;
    closing_q     <= closing_d;
    out_found_q   <= out_found_d;
    out_closing_q <= out_closing_d;
  end

  // Wait rows, with the row's valid bit captured alongside the read
  always_ff @(posedge clk_i) begin
    if (wait_we) begin
      wait_mem[wait_waddr] <= wait_wdata;
    end
    if (wait_re) begin
      wait_rdata_q <= wait_mem[wait_raddr];
      wait_rvld_q  <= row_vld_q[wait_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (holder_we) begin
      holder_mem[holder_waddr] <= holder_wdata;
    end
    if (holder_re) begin
      holder_rdata_q <= holder_mem[holder_raddr];
    end
  end

  // Search path: parent frames {slot, resume cursor}; the top frame is in registers
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    if (stack_re) begin
      stack_rdata_q <= stack_mem[stack_raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign deadlock_found_o = out_found_q;
  assign closing_slot_o   = out_closing_q;

  // A slot is never on the path and finished at once
  a_marks_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (on_path_q & done_q) == '0)
    else $error("slot both on path and finished");

  // The node being scanned is always on the path
  a_scan_on_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> on_path_q[cur_slot_q])
    else $error("scanned node not on path");

  // Path depth stays within the slot count while searching
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_HOLDER) |->
      (sp_q != '0 && sp_q <= SPW'(PROCESS_SLOTS)))
    else $error("search depth out of range");

  // A result only appears when a check reports
  a_result_from_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_REPORT)
    else $error("result word without a check");

  // Number of marked slots on the path equals the depth while scanning
  a_path_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ($countones(on_path_q) == int'(sp_q)))
    else $error("path marks disagree with depth");

endmodule
